// ----- hw/rtl/sem_pkg.sv -----
// shared constants for the sobel edge magnitude core
// field widths, register reset values and root unit sizing; no dependencies
package sem_pkg;

    localparam int PIXEL_W            = 8;
    localparam int LINE_WIDTH_W       = 11;
    localparam int LINE_WIDTH_RESET   = 640;
    localparam int LINE_WIDTH_MIN     = 3;
    localparam int MAX_WIDTH_DEFAULT  = 1024;
    localparam int APB_DATA_W         = 32;
    localparam int APB_ADDR_W         = 3;

    // radicand below 2**RADICAND_W gives an 8-bit root, anything larger saturates
    localparam int RADICAND_W         = 16;
    localparam int ROOT_W             = RADICAND_W / 2;
    localparam int SAT_VALUE          = 255;

    // register index on the config port
    localparam logic REG_LINE_WIDTH   = 1'b0;

endpackage

// ----- hw/rtl/sobel_edge_magnitude_core.sv -----
// Sobel edge magnitude core: pixels in raster order in, one magnitude byte out per pixel.
// The line store is read at the edge that accepts a pixel; the window and gradients are
// then formed and registered (ST_CALC), the squares are summed and the square root unit
// started (ST_SQUARE), and the output register is loaded once the root is done and the
// output is free (ST_ROOT). The bit-serial root keeps the core from taking the next pixel
// until the result is loaded. The result refers to the pixel one row and one column back;
// positions whose center lies on the top or left border give 0. A new pixel is taken while
// a finished result waits on the output. The line stores need no clearing pass after reset.
// depends on sem_pkg and sem_isqrt
module sobel_edge_magnitude_core #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sem_pkg::PIXEL_W-1:0]     s_tdata,   // [7:0] pixel
    input  logic                            s_tuser,   // [0] frame_start
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sem_pkg::PIXEL_W-1:0]     m_tdata,   // [7:0] edge_res
    output logic                            m_tuser,   // [0] frame_start_out
    // config port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sem_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sem_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sem_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import sem_pkg::*;

    localparam int COL_W   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_W   = ((COL_W + 1) > LINE_WIDTH_W) ? (COL_W + 1) : LINE_WIDTH_W;
    localparam int SUM_W   = PIXEL_W + 2;
    localparam int GRAD_W  = SUM_W + 1;
    localparam int SQ_W    = 2 * SUM_W;
    localparam int LINE_W  = 2 * PIXEL_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_SQUARE,
        ST_ROOT
    } state_t;

    state_t                  state_reg;
    logic [LINE_WIDTH_W-1:0] line_width_reg;

    // line store memory: upper row in the low byte, middle row in the high byte
    logic [LINE_W-1:0]       line_mem [MAX_WIDTH];
    logic [LINE_W-1:0]       line_rd_reg;

    logic [PIXEL_W-1:0]      px_reg;
    logic                    fs_reg;
    logic [COL_W-1:0]        col_reg;
    logic [1:0]              row_reg;
    logic [COL_W-1:0]        col_cur_reg;
    logic [1:0]              row_cur_reg;
    logic [PIXEL_W-1:0]      win_reg [6];
    logic [SUM_W-1:0]        ax_reg;
    logic [SUM_W-1:0]        ay_reg;
    logic                    inner_reg;
    logic                    sat_reg;

    logic                    m_tvalid_reg;
    logic [PIXEL_W-1:0]      m_tdata_reg;
    logic                    m_tuser_reg;

    logic                    in_req;
    logic                    out_free;
    logic                    out_load;
    logic                    cfg_wr;
    logic [COL_W-1:0]        col_acc;
    logic [CMP_W-1:0]        w_eff;
    logic [CMP_W-1:0]        col_inc;
    logic [PIXEL_W-1:0]      top;
    logic [PIXEL_W-1:0]      mid;
    logic [SUM_W-1:0]        gx_pos;
    logic [SUM_W-1:0]        gx_neg;
    logic [SUM_W-1:0]        gy_pos;
    logic [SUM_W-1:0]        gy_neg;
    logic [GRAD_W-1:0]       gx;
    logic [GRAD_W-1:0]       gy;
    logic [SUM_W-1:0]        ax;
    logic [SUM_W-1:0]        ay;
    logic [SQ_W-1:0]         ax_sq;
    logic [SQ_W-1:0]         ay_sq;
    logic [SQ_W:0]           sq_sum;
    logic                    root_start;
    logic                    root_busy;
    logic [ROOT_W-1:0]       root;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_req   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_ROOT) && !root_busy && out_free;
    assign col_acc  = s_tuser ? '0 : col_reg;

    // clamp the programmed width into the supported range
    always_comb begin
        if (line_width_reg < LINE_WIDTH_W'(LINE_WIDTH_MIN)) begin
            w_eff = CMP_W'(LINE_WIDTH_MIN);
        end else if (CMP_W'(line_width_reg) > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = CMP_W'(line_width_reg);
        end
    end
    assign col_inc = CMP_W'(col_cur_reg) + 1'b1;

    // sobel kernels on window {c-2, c-1, c}
    assign top    = line_rd_reg[PIXEL_W-1:0];
    assign mid    = line_rd_reg[LINE_W-1:PIXEL_W];
    assign gx_pos = {2'b00, top} + {1'b0, mid, 1'b0} + {2'b00, px_reg};
    assign gx_neg = {2'b00, win_reg[0]} + {1'b0, win_reg[1], 1'b0} + {2'b00, win_reg[2]};
    assign gy_pos = {2'b00, win_reg[2]} + {1'b0, win_reg[5], 1'b0} + {2'b00, px_reg};
    assign gy_neg = {2'b00, win_reg[0]} + {1'b0, win_reg[3], 1'b0} + {2'b00, top};
    assign gx     = {1'b0, gx_pos} - {1'b0, gx_neg};
    assign gy     = {1'b0, gy_pos} - {1'b0, gy_neg};
    assign ax     = gx[GRAD_W-1] ? SUM_W'(-gx) : gx[SUM_W-1:0];
    assign ay     = gy[GRAD_W-1] ? SUM_W'(-gy) : gy[SUM_W-1:0];

    assign ax_sq      = ax_reg * ax_reg;
    assign ay_sq      = ay_reg * ay_reg;
    assign sq_sum     = {1'b0, ax_sq} + {1'b0, ay_sq};
    assign root_start = (state_reg == ST_SQUARE);

    sem_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (sq_sum[RADICAND_W-1:0]),
        .busy     (root_busy),
        .root     (root)
    );

    // line stores: read on acceptance, write back shifted rows in the following cycle
    always_ff @(posedge aclk) begin
        if (in_req) begin
            line_rd_reg <= line_mem[col_acc];
        end
        if (state_reg == ST_CALC) begin
            line_mem[col_cur_reg] <= {px_reg, mid};
        end
    end

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb begin
        unique case (paddr[2])
            REG_LINE_WIDTH: prdata = APB_DATA_W'(line_width_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= LINE_WIDTH_W'(LINE_WIDTH_RESET);
        end else if (cfg_wr && (paddr[2] == REG_LINE_WIDTH)) begin
            line_width_reg <= pwdata[LINE_WIDTH_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            col_reg      <= '0;
            row_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_req) begin
                        px_reg      <= s_tdata;
                        fs_reg      <= s_tuser;
                        col_cur_reg <= col_acc;
                        row_cur_reg <= s_tuser ? 2'd0 : row_reg;
                        state_reg   <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    ax_reg     <= ax;
                    ay_reg     <= ay;
                    inner_reg  <= (row_cur_reg == 2'd2) && (col_cur_reg >= COL_W'(2));
                    win_reg[0] <= win_reg[3];
                    win_reg[1] <= win_reg[4];
                    win_reg[2] <= win_reg[5];
                    win_reg[3] <= top;
                    win_reg[4] <= mid;
                    win_reg[5] <= px_reg;
                    if (col_inc >= w_eff) begin
                        col_reg <= '0;
                        row_reg <= (row_cur_reg == 2'd2) ? 2'd2 : row_cur_reg + 1'b1;
                    end else begin
                        col_reg <= COL_W'(col_inc);
                        row_reg <= row_cur_reg;
                    end
                    state_reg <= ST_SQUARE;
                end
                ST_SQUARE: begin
                    sat_reg   <= |sq_sum[SQ_W:RADICAND_W];
                    state_reg <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (out_load) begin
                        m_tuser_reg  <= fs_reg;
                        if (!inner_reg) begin
                            m_tdata_reg <= '0;
                        end else if (sat_reg) begin
                            m_tdata_reg <= PIXEL_W'(SAT_VALUE);
                        end else begin
                            m_tdata_reg <= root;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- hw/rtl/sem_isqrt.sv -----
// digit-by-digit floor square root, one result bit per cycle
// depends on sem_pkg for radicand and root widths
module sem_isqrt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [sem_pkg::RADICAND_W-1:0]  radicand,
    output logic                            busy,
    output logic [sem_pkg::ROOT_W-1:0]      root
);
    import sem_pkg::*;

    localparam int REM_W   = ROOT_W + 1;
    localparam int SH_W    = REM_W + 2;
    localparam int STEP_W  = $clog2(ROOT_W);

    logic [RADICAND_W-1:0] rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  busy_reg;

    logic [SH_W-1:0]       rem_sh;
    logic [SH_W-1:0]       trial;
    logic                  fits;

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {rem_reg, rad_reg[RADICAND_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RADICAND_W-3:0], 2'b00};
            if (fits) begin
                rem_reg  <= REM_W'(rem_sh - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= REM_W'(rem_sh);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(ROOT_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule
